// File: rtl/core/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared types, constants and helpers for the triangle/box overlap block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbo_pkg;

  // default coordinate width, signed Q16.8
  localparam int COORD_W_DEF = 24;

  // box half extent register width and reset value (0.5 in Q16.8)
  localparam int HALF_W = 23;
  localparam logic [HALF_W-1:0] HALF_RST = 23'd128;

  // items per transaction
  localparam int NUM_FIELDS = 12;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2
  } reg_idx_t;

  // first and second box component used by the edge cross axis for box axis k
  function automatic int c1_of(input int k);
    return (k == 0) ? 1 : 0;
  endfunction

  function automatic int c2_of(input int k);
    return (k == 2) ? 1 : 2;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/triangle_box_overlap.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap
// Separating-axis test of a triangle against an axis-aligned box, pipelined.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; the seven stages advance together
// whenever the output register is empty or being taken.
// Reset: synchronous active-low rst_n clears stage valid bits and the output
// valid, and sets half_x, half_y and half_z to 128 (0.5).
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_box_overlap #(
  parameter int COORD_WIDTH = tbo_pkg::COORD_W_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // center_x, center_y, center_z, vert0_x..z, vert1_x..z, vert2_x..z
  input  logic [((tbo_pkg::NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // overlaps
  output logic [7:0]                                    out_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  input  logic                                          cfg_we,
  input  logic [1:0]                                    cfg_addr,
  input  logic [tbo_pkg::HALF_W-1:0]                    cfg_wdata
);
  import tbo_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int UW  = W + 1;            // box-space coordinate
  localparam int EW  = W + 2;            // edge component
  localparam int PW  = EW + UW;          // cross projection product
  localparam int QW  = PW + 1;           // cross projection
  localparam int RPW = HALF_W + EW;      // cross radius product
  localparam int RW  = RPW + 1;          // cross radius
  localparam int BW  = UW + HALF_W;      // box axis compare width
  localparam int XW  = 2 * W + HALF_W;   // cross axis compare width
  localparam int NPW = 2 * EW;           // normal product
  localparam int NW  = NPW + 1;          // normal component
  localparam int NL  = NW / 2;           // low split of normal
  localparam int NH  = NW - NL;          // high split of normal
  localparam int DLW = NL + 1 + UW;
  localparam int DHW = NH + UW;
  localparam int RLW = NL + HALF_W;
  localparam int RHW = NH + HALF_W;
  localparam int DW  = NW + UW + 2;      // plane distance
  localparam int RDW = NW + HALF_W + 2;  // plane radius
  localparam int TW  = NW + UW + HALF_W + 2;

  // configuration registers
  logic [HALF_W-1:0] half_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r[0] <= HALF_RST;
      half_r[1] <= HALF_RST;
      half_r[2] <= HALF_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_HALF_X: half_r[0] <= cfg_wdata;
        REG_HALF_Y: half_r[1] <= cfg_wdata;
        REG_HALF_Z: half_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: output register empty or being taken
  logic en;
  logic [6:1] vld_r;
  logic out_valid_r;
  logic out_ovl_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_ovl_r};

  // unpack input transaction
  logic signed [W-1:0] fld [NUM_FIELDS];
  always_comb begin
    for (int f = 0; f < NUM_FIELDS; f++) fld[f] = signed'(in_tdata[f*W +: W]);
  end

  // stage 1: translate vertices to box space
  logic signed [UW-1:0] u1_nxt [3][3];
  logic signed [UW-1:0] u1_r   [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        u1_nxt[i][k] = UW'(fld[3 + 3*i + k]) - UW'(fld[k]);
  end

  // stage 2: edges and box axis rejection
  logic signed [EW-1:0] e2_nxt [3][3];
  logic signed [EW-1:0] e2_r   [3][3];
  logic signed [UW-1:0] u2_r   [3][3];
  logic [2:0]           box_out;
  logic                 rejb2_r;
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        e2_nxt[i][k] = EW'(u1_r[(i + 1) % 3][k]) - EW'(u1_r[i][k]);
  end

  for (genvar k = 0; k < 3; k++) begin : g_box
    tbo_outside #(.VAL_W(BW)) u_box (
      .p0      (BW'(u1_r[0][k])),
      .p1      (BW'(u1_r[1][k])),
      .p2      (BW'(u1_r[2][k])),
      .rad     (signed'(BW'(half_r[k]))),
      .outside (box_out[k])
    );
  end

  // stage 3: all first-level products
  logic signed [PW-1:0]  pa3_nxt [3][3][3];
  logic signed [PW-1:0]  pb3_nxt [3][3][3];
  logic        [RPW-1:0] ra3_nxt [3][3];
  logic        [RPW-1:0] rb3_nxt [3][3];
  logic signed [NPW-1:0] np3_nxt [6];
  logic        [EW-1:0]  ae      [3][3];
  logic signed [PW-1:0]  pa3_r   [3][3][3];
  logic signed [PW-1:0]  pb3_r   [3][3][3];
  logic        [RPW-1:0] ra3_r   [3][3];
  logic        [RPW-1:0] rb3_r   [3][3];
  logic signed [NPW-1:0] np3_r   [6];
  logic signed [UW-1:0]  u3_r    [3];
  logic                  rejb3_r;

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        ae[i][k] = e2_r[i][k][EW-1] ? EW'(-e2_r[i][k]) : EW'(e2_r[i][k]);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pa3_nxt[i][k][j] = PW'(e2_r[i][c2_of(k)]) * PW'(u2_r[j][c1_of(k)]);
          pb3_nxt[i][k][j] = PW'(e2_r[i][c1_of(k)]) * PW'(u2_r[j][c2_of(k)]);
        end
        ra3_nxt[i][k] = RPW'(half_r[c1_of(k)]) * RPW'(ae[i][c2_of(k)]);
        rb3_nxt[i][k] = RPW'(half_r[c2_of(k)]) * RPW'(ae[i][c1_of(k)]);
      end
    end
    np3_nxt[0] = NPW'(e2_r[0][1]) * NPW'(e2_r[1][2]);
    np3_nxt[1] = NPW'(e2_r[0][2]) * NPW'(e2_r[1][1]);
    np3_nxt[2] = NPW'(e2_r[0][2]) * NPW'(e2_r[1][0]);
    np3_nxt[3] = NPW'(e2_r[0][0]) * NPW'(e2_r[1][2]);
    np3_nxt[4] = NPW'(e2_r[0][0]) * NPW'(e2_r[1][1]);
    np3_nxt[5] = NPW'(e2_r[0][1]) * NPW'(e2_r[1][0]);
  end

  // stage 4: normal, cross projections and radii
  logic signed [NW-1:0] n4_nxt [3];
  logic signed [QW-1:0] p4_nxt [3][3][3];
  logic        [RW-1:0] r4_nxt [3][3];
  logic signed [NW-1:0] n4_r   [3];
  logic signed [QW-1:0] p4_r   [3][3][3];
  logic        [RW-1:0] r4_r   [3][3];
  logic signed [UW-1:0] u4_r   [3];
  logic                 rejb4_r;

  always_comb begin
    for (int m = 0; m < 3; m++)
      n4_nxt[m] = NW'(np3_r[2*m]) - NW'(np3_r[2*m + 1]);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++)
          p4_nxt[i][k][j] = QW'(pa3_r[i][k][j]) - QW'(pb3_r[i][k][j]);
        r4_nxt[i][k] = RW'(ra3_r[i][k]) + RW'(rb3_r[i][k]);
      end
  end

  // stage 5: plane split products and cross axis rejection
  logic        [NW-1:0]  an      [3];
  logic signed [DLW-1:0] dlo5_nxt [3];
  logic signed [DHW-1:0] dhi5_nxt [3];
  logic        [RLW-1:0] rlo5_nxt [3];
  logic        [RHW-1:0] rhi5_nxt [3];
  logic signed [DLW-1:0] dlo5_r   [3];
  logic signed [DHW-1:0] dhi5_r   [3];
  logic        [RLW-1:0] rlo5_r   [3];
  logic        [RHW-1:0] rhi5_r   [3];
  logic [8:0]            x_out;
  logic                  rej5_r;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      an[m]       = n4_r[m][NW-1] ? NW'(-n4_r[m]) : NW'(n4_r[m]);
      dlo5_nxt[m] = DLW'(signed'({1'b0, n4_r[m][NL-1:0]})) * DLW'(u4_r[m]);
      dhi5_nxt[m] = DHW'(signed'(n4_r[m][NW-1:NL])) * DHW'(u4_r[m]);
      rlo5_nxt[m] = RLW'(an[m][NL-1:0]) * RLW'(half_r[m]);
      rhi5_nxt[m] = RHW'(an[m][NW-1:NL]) * RHW'(half_r[m]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_xi
    for (genvar k = 0; k < 3; k++) begin : g_xk
      tbo_outside #(.VAL_W(XW)) u_cross (
        .p0      (XW'(p4_r[i][k][0])),
        .p1      (XW'(p4_r[i][k][1])),
        .p2      (XW'(p4_r[i][k][2])),
        .rad     (signed'(XW'(r4_r[i][k]))),
        .outside (x_out[3*i + k])
      );
    end
  end

  // stage 6: plane distance and plane radius
  logic signed [DW-1:0]  d6_nxt;
  logic        [RDW-1:0] rad6_nxt;
  logic signed [DW-1:0]  d6_r;
  logic        [RDW-1:0] rad6_r;
  logic                  rej6_r;

  always_comb begin
    d6_nxt   = '0;
    rad6_nxt = '0;
    for (int m = 0; m < 3; m++) begin
      d6_nxt   = d6_nxt + (DW'(dhi5_r[m]) <<< NL) + DW'(dlo5_r[m]);
      rad6_nxt = rad6_nxt + (RDW'(rhi5_r[m]) << NL) + RDW'(rlo5_r[m]);
    end
  end

  // stage 7: plane test and final flag
  logic [DW-1:0] abs_d;
  logic          ovl_nxt;
  assign abs_d   = d6_r[DW-1] ? DW'(-d6_r) : DW'(d6_r);
  assign ovl_nxt = !rej6_r && !(TW'(rad6_r) < TW'(abs_d));

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      u1_r    <= u1_nxt;
      e2_r    <= e2_nxt;
      u2_r    <= u1_r;
      rejb2_r <= |box_out;
      pa3_r   <= pa3_nxt;
      pb3_r   <= pb3_nxt;
      ra3_r   <= ra3_nxt;
      rb3_r   <= rb3_nxt;
      np3_r   <= np3_nxt;
      u3_r    <= u2_r[0];
      rejb3_r <= rejb2_r;
      n4_r    <= n4_nxt;
      p4_r    <= p4_nxt;
      r4_r    <= r4_nxt;
      u4_r    <= u3_r;
      rejb4_r <= rejb3_r;
      dlo5_r  <= dlo5_nxt;
      dhi5_r  <= dhi5_nxt;
      rlo5_r  <= rlo5_nxt;
      rhi5_r  <= rhi5_nxt;
      rej5_r  <= rejb4_r || (|x_out);
      d6_r    <= d6_nxt;
      rad6_r  <= rad6_nxt;
      rej6_r  <= rej5_r;
    end
    if (en && vld_r[6]) out_ovl_r <= ovl_nxt;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[5:1], in_tvalid};
      out_valid_r <= vld_r[6];
    end
  end

`ifndef ASSERT_OFF
  // accepted transaction enters stage one
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[1])
    else $error("accepted transaction lost at stage one");

  // pipeline never blocks input while output register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  // last stage moves into the output register on advance
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[6]) |=> out_valid_r)
    else $error("result dropped between last stage and output");

  // a held pipeline keeps its valid pattern
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("stage valid changed during stall");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tbo_outside.sv
// ----------------------------------------------------------------------------
// tbo_outside
// Range check: true when three projections lie wholly outside [-r, r].
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_outside #(
  parameter int VAL_W = 48
) (
  input  logic signed [VAL_W-1:0] p0,
  input  logic signed [VAL_W-1:0] p1,
  input  logic signed [VAL_W-1:0] p2,
  input  logic signed [VAL_W-1:0] rad,
  output logic                    outside
);
  import tbo_pkg::*;

  logic signed [VAL_W-1:0] mn;
  logic signed [VAL_W-1:0] mx;
  logic signed [VAL_W-1:0] neg_rad;

  // min and max of the three projections
  always_comb begin
    mn = p0;
    mx = p0;
    if (p1 < mn) mn = p1;
    if (p2 < mn) mn = p2;
    if (mx < p1) mx = p1;
    if (mx < p2) mx = p2;
  end

  // strict compares, touching is not outside
  assign neg_rad = -rad;
  assign outside = (rad < mn) || (mx < neg_rad);

endmodule

`default_nettype wire
